// ----- src/binned_cross_power_accumulator_assert.svh -----
// assertion macros for the binned cross power accumulator
`ifndef BINNED_CROSS_POWER_ACCUMULATOR_ASSERT_SVH
`define BINNED_CROSS_POWER_ACCUMULATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BCPA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcpa check failed");
`define BCPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcpa check failed");
`else
`define BCPA_ASSERT_SAME(lbl, ante, cons)
`define BCPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/bcpa_pkg.sv -----
package bcpa_pkg;

    localparam int NUM_BINS    = 64;
    localparam int NUM_MAPS    = 4;
    localparam int PAIRS       = 10;
    localparam int SAMPLE_BITS = 24;
    localparam int KSQ_BITS    = 32;
    localparam int EDGE_DEPTH  = NUM_BINS + 1;
    localparam int SUM_DEPTH   = NUM_BINS * PAIRS;
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
    localparam int SUM_AW      = $clog2(SUM_DEPTH);
    localparam int CNT_AW      = $clog2(NUM_BINS);

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic {
        REG_MAPS = 1'b0,
        REG_BINS = 1'b1
    } reg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // pair order 00,01,11,02,12,22,03,13,23,33
    localparam logic [1:0] PAIR_M [PAIRS] =
        '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3};
    localparam logic [1:0] PAIR_N [PAIRS] =
        '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};

    function automatic logic [3:0] pair_count(input logic [2:0] nm);
        logic [3:0] r;
        unique case (nm)
            3'd1:    r = 4'd1;
            3'd2:    r = 4'd3;
            3'd3:    r = 4'd6;
            3'd4:    r = 4'd10;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- src/bcpa_ram.sv -----
module bcpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/binned_cross_power_accumulator.sv -----
// channel   direction  handshake           payload
// in        to block   in_valid/in_stall   operation, k_squared, mode_weight, index, re0..im3
// out       from block out_valid/out_stall bin_index, mode_total, auto00..auto33, cross01..cross23
// cfg       to block   apb psel/penable    maps_in_use at 0x0, bins_in_use at 0x4
// load edge writes one edge memory entry; clear all bins zeroes all 640 sum entries, one sum entry per cycle
// accumulate scans the edge memory, one edge memory read per cycle, then does the sum
// memory read-modify-write for each active pair in states S_ACC_A and S_ACC_B
// read bin gathers all ten sum entries, one per S_RD_A/S_RD_B pass, and waits for a held result
// after reset a clearing pass over all 640 sum entries runs before the first request is taken
// in_stall is high whenever the sequencer is busy; out_stall only holds the result
`include "binned_cross_power_accumulator_assert.svh"
module binned_cross_power_accumulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [bcpa_pkg::KSQ_BITS-1:0]  k_squared,
    input  logic [1:0]                     mode_weight,
    input  logic [6:0]                     index,
    input  bcpa_pkg::sample_t              re0,
    input  bcpa_pkg::sample_t              im0,
    input  bcpa_pkg::sample_t              re1,
    input  bcpa_pkg::sample_t              im1,
    input  bcpa_pkg::sample_t              re2,
    input  bcpa_pkg::sample_t              im2,
    input  bcpa_pkg::sample_t              re3,
    input  bcpa_pkg::sample_t              im3,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [5:0]                     bin_index,
    output logic [31:0]                    mode_total,
    output logic [62:0]                    auto00,
    output logic signed [63:0]             cross01,
    output logic [62:0]                    auto11,
    output logic signed [63:0]             cross02,
    output logic signed [63:0]             cross12,
    output logic [62:0]                    auto22,
    output logic signed [63:0]             cross03,
    output logic signed [63:0]             cross13,
    output logic signed [63:0]             cross23,
    output logic [62:0]                    auto33
);
    import bcpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_SCAN, S_ACC_A, S_ACC_B, S_RD_WAIT, S_RD_A, S_RD_B
    } state_t;

    state_t                state_reg;
    logic [2:0]            maps_reg;
    logic [6:0]            bins_reg;
    logic [KSQ_BITS-1:0]   ksq_reg;
    logic [1:0]            wt_reg;
    sample_t               re_reg [NUM_MAPS];
    sample_t               im_reg [NUM_MAPS];
    logic [SUM_AW-1:0]     clr_reg;
    logic [EDGE_AW-1:0]    scan_reg;
    logic                  chk_vld_reg;
    logic [EDGE_AW-1:0]    chk_addr_reg;
    logic                  below_reg;
    logic [5:0]            bin_reg;
    logic [3:0]            pair_reg;
    logic signed [47:0]    mul_re_reg;
    logic signed [47:0]    mul_im_reg;
    logic                  out_valid_reg;
    logic [5:0]            out_bin_reg;
    logic [31:0]           out_cnt_reg;
    logic [63:0]           out_sum_reg [PAIRS];

    logic                  in_take;
    logic                  cfg_write;
    logic [2:0]            nm_act;
    logic [6:0]            nb_act;
    logic [3:0]            npairs;
    logic [SUM_AW-1:0]     sum_addr;

    logic                  edge_we;
    logic [KSQ_BITS-1:0]   edge_rdata;
    logic                  sum_we;
    logic [SUM_AW-1:0]     sum_waddr;
    logic [63:0]           sum_wdata;
    logic [63:0]           sum_rdata;
    logic                  cnt_we;
    logic [CNT_AW-1:0]     cnt_waddr;
    logic [31:0]           cnt_wdata;
    logic [31:0]           cnt_rdata;

    logic signed [48:0]    pair_sum;
    logic signed [50:0]    pair_wt;
    logic signed [64:0]    acc_sum;
    logic [63:0]           acc_sat;
    logic [32:0]           cnt_sum;
    logic                  last_pair;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx_t'(paddr[2]) == REG_BINS) ? {25'd0, bins_reg}
                                                           : {29'd0, maps_reg};

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    assign nm_act = (maps_reg == 3'd0) ? 3'd1 :
                    (maps_reg > 3'(NUM_MAPS)) ? 3'(NUM_MAPS) : maps_reg;
    assign nb_act = (bins_reg == 7'd0) ? 7'd1 :
                    (bins_reg > 7'(NUM_BINS)) ? 7'(NUM_BINS) : bins_reg;
    assign npairs = pair_count(nm_act);
    assign last_pair = (pair_reg == npairs - 4'd1);

    // bin * 10 + pair
    assign sum_addr = SUM_AW'({bin_reg, 3'b000}) + SUM_AW'({bin_reg, 1'b0})
                    + SUM_AW'(pair_reg);

    // pair product, weight and saturating add
    assign pair_sum = {mul_re_reg[47], mul_re_reg} + {mul_im_reg[47], mul_im_reg};
    assign pair_wt  = (wt_reg[0] ? {{2{pair_sum[48]}}, pair_sum} : 51'sd0)
                    + (wt_reg[1] ? {pair_sum[48], pair_sum, 1'b0} : 51'sd0);
    assign acc_sum  = {sum_rdata[63], sum_rdata} + {{14{pair_wt[50]}}, pair_wt};
    assign acc_sat  = (acc_sum[64] == acc_sum[63]) ? acc_sum[63:0] :
                      (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
    assign cnt_sum  = {1'b0, cnt_rdata} + {31'd0, wt_reg};

    assign edge_we = in_take && (op_t'(operation) == OP_LOAD)
                     && (index <= 7'(NUM_BINS));

    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = sum_addr;
        sum_wdata = acc_sat;
        cnt_we    = 1'b0;
        cnt_waddr = bin_reg;
        cnt_wdata = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
        if (state_reg == S_CLEAR)
        begin
            sum_we    = 1'b1;
            sum_waddr = clr_reg;
            sum_wdata = '0;
            cnt_we    = (clr_reg < SUM_AW'(NUM_BINS));
            cnt_waddr = clr_reg[CNT_AW-1:0];
            cnt_wdata = '0;
        end
        else if (state_reg == S_ACC_B)
        begin
            sum_we = 1'b1;
            cnt_we = last_pair;
        end
    end

    bcpa_ram #(.WIDTH(KSQ_BITS), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (index),
        .wdata (k_squared),
        .raddr (scan_reg),
        .rdata (edge_rdata)
    );

    bcpa_ram #(.WIDTH(64), .DEPTH(SUM_DEPTH)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_addr),
        .rdata (sum_rdata)
    );

    bcpa_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (bin_reg),
        .rdata (cnt_rdata)
    );

    // payload, product and output registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ksq_reg   <= k_squared;
            wt_reg    <= mode_weight;
            re_reg[0] <= re0;
            im_reg[0] <= im0;
            re_reg[1] <= re1;
            im_reg[1] <= im1;
            re_reg[2] <= re2;
            im_reg[2] <= im2;
            re_reg[3] <= re3;
            im_reg[3] <= im3;
        end
        if (state_reg == S_ACC_A)
        begin
            mul_re_reg <= re_reg[PAIR_M[pair_reg]] * re_reg[PAIR_N[pair_reg]];
            mul_im_reg <= im_reg[PAIR_M[pair_reg]] * im_reg[PAIR_N[pair_reg]];
        end
        if (state_reg == S_RD_B)
        begin
            out_sum_reg[pair_reg] <= sum_rdata;
            if (pair_reg == 4'd0)
            begin
                out_cnt_reg <= cnt_rdata;
            end
        end
        if (state_reg == S_RD_WAIT && !out_valid_reg)
        begin
            out_bin_reg <= bin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            maps_reg      <= 3'd1;
            bins_reg      <= 7'(NUM_BINS);
            clr_reg       <= '0;
            scan_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            chk_addr_reg  <= '0;
            below_reg     <= 1'b0;
            bin_reg       <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (reg_idx_t'(paddr[2]) == REG_BINS)
                begin
                    bins_reg <= pwdata[6:0];
                end
                else
                begin
                    maps_reg <= pwdata[2:0];
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        unique case (op_t'(operation))
                            OP_ACCUM:
                            begin
                                state_reg   <= S_SCAN;
                                scan_reg    <= '0;
                                chk_vld_reg <= 1'b0;
                                below_reg   <= 1'b0;
                                bin_reg     <= '0;
                            end
                            OP_READ:
                            begin
                                if (index < nb_act)
                                begin
                                    state_reg <= S_RD_WAIT;
                                    bin_reg   <= index[5:0];
                                end
                            end
                            OP_LOAD:
                            begin
                                state_reg <= S_IDLE;
                            end
                            OP_CLEAR:
                            begin
                                state_reg <= S_CLEAR;
                                clr_reg   <= '0;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SUM_AW'(SUM_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    // bin = count of inner edges at or below k squared
                    if (scan_reg <= nb_act)
                    begin
                        scan_reg    <= scan_reg + 1'b1;
                        chk_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                    chk_addr_reg <= scan_reg;
                    if (chk_vld_reg)
                    begin
                        if (chk_addr_reg == '0)
                        begin
                            below_reg <= (ksq_reg < edge_rdata);
                        end
                        else if (chk_addr_reg == nb_act)
                        begin
                            pair_reg <= '0;
                            if (below_reg || (ksq_reg >= edge_rdata))
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_ACC_A;
                            end
                        end
                        else if (edge_rdata <= ksq_reg)
                        begin
                            bin_reg <= bin_reg + 1'b1;
                        end
                    end
                end
                S_ACC_A:
                begin
                    state_reg <= S_ACC_B;
                end
                S_ACC_B:
                begin
                    if (last_pair)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pair_reg  <= pair_reg + 1'b1;
                        state_reg <= S_ACC_A;
                    end
                end
                S_RD_WAIT:
                begin
                    pair_reg <= '0;
                    if (!out_valid_reg)
                    begin
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A:
                begin
                    state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    if (pair_reg == 4'(PAIRS - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        pair_reg  <= pair_reg + 1'b1;
                        state_reg <= S_RD_A;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_index  = out_bin_reg;
    assign mode_total = out_cnt_reg;
    assign auto00     = out_sum_reg[0][62:0];
    assign cross01    = signed'(out_sum_reg[1]);
    assign auto11     = out_sum_reg[2][62:0];
    assign cross02    = signed'(out_sum_reg[3]);
    assign cross12    = signed'(out_sum_reg[4]);
    assign auto22     = out_sum_reg[5][62:0];
    assign cross03    = signed'(out_sum_reg[6]);
    assign cross13    = signed'(out_sum_reg[7]);
    assign cross23    = signed'(out_sum_reg[8]);
    assign auto33     = out_sum_reg[9][62:0];

    `BCPA_ASSERT_SAME(a_no_sum_write_idle, state_reg == S_IDLE, !sum_we)
    `BCPA_ASSERT_SAME(a_gather_hidden, state_reg == S_RD_A || state_reg == S_RD_B,
        !out_valid_reg)
    `BCPA_ASSERT_SAME(a_bin_in_range, state_reg == S_SCAN, {1'b0, bin_reg} < nb_act)
    `BCPA_ASSERT_NEXT(a_clear_ends,
        state_reg == S_CLEAR && clr_reg == SUM_AW'(SUM_DEPTH - 1), state_reg == S_IDLE)

endmodule
